[hw/rtl/ibf_pkg.sv]
`default_nettype none

package ibf_pkg;

   localparam int AddrW      = 32;
   localparam int IndexW     = 19;
   localparam int WordW      = 32;
   localparam int BitSelW    = $clog2(WordW);
   localparam int StoreDepth = 16384;
   localparam int WordAddrW  = $clog2(StoreDepth);
   localparam int HashCount  = 14;
   localparam int CntW       = (HashCount > 1) ? $clog2(HashCount) : 1;

   // request mode codes
   localparam logic ModeInsert = 1'b0;
   localparam logic ModeQuery  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_FINISH,
      ST_POST
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              set;
      logic [IndexW-1:0] index;
   } probe_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/ibf_store.sv]
`default_nettype none

module ibf_store
   import ibf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire probe_type            probe,
   input  wire logic                 clear_en,
   input  wire logic [WordAddrW-1:0] clear_addr,
   output      result_type           result
);

   logic [WordW-1:0] bits_mem [StoreDepth];

   logic [WordW-1:0]     rd_data_ff;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_set_ff;
   logic [WordAddrW-1:0] s1_word_ff;
   logic [BitSelW-1:0]   s1_bit_ff;

   logic                 fwd_valid_ff, fwd_valid_in;
   logic [WordAddrW-1:0] fwd_word_ff;
   logic [WordW-1:0]     fwd_data_ff;

   logic [WordW-1:0]     cur_word;
   logic                 wr_en;
   logic [WordAddrW-1:0] wr_addr;
   logic [WordW-1:0]     wr_data;
   logic                 set_write;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bits_mem[wr_addr] <= wr_data;
      end
      if (probe.valid) begin
         rd_data_ff <= bits_mem[probe.index[IndexW-1:BitSelW]];
      end
   end

   assign s1_valid_in = probe.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_set_ff   <= probe.set;
      s1_word_ff  <= probe.index[IndexW-1:BitSelW];
      s1_bit_ff   <= probe.index[BitSelW-1:0];
      fwd_word_ff <= s1_word_ff;
      fwd_data_ff <= wr_data;
   end

   // the previous write lands in the same cycle this read was issued: forward it
   always_comb begin
      if (fwd_valid_ff && (fwd_word_ff == s1_word_ff)) begin
         cur_word = fwd_data_ff;
      end else begin
         cur_word = rd_data_ff;
      end
   end

   assign set_write    = s1_valid_ff && s1_set_ff;
   assign fwd_valid_in = set_write;

   always_comb begin
      if (clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr;
         wr_data = '0;
      end else begin
         wr_en   = set_write;
         wr_addr = s1_word_ff;
         wr_data = cur_word | (WordW'(1) << s1_bit_ff);
      end
   end

   assign result.valid = s1_valid_ff;
   assign result.hit   = cur_word[s1_bit_ff];

endmodule

`default_nettype wire

[hw/rtl/ipv4_bloom_filter.sv]
// IPv4 bloom filter.
// Request channel (req_valid / req_stall): one word carries req_mode and
// req_address. Mode insert marks the address, mode query tests it.
// Response channel (rsp_valid / rsp_stall): one word per query, carrying
// rsp_maybe_present; inserts produce no response word.
// Each address is probed with 14 windows of 19 bits, in the forward store
// on the address and in the reversed store on its bit mirror. Both stores
// are 16384 x 32 synchronous memories run in parallel, one read-modify-write
// probe per cycle each, with a one-entry forward path between back-to-back
// probes of the same word.
// Each word runs through accept, one probe per window, a finish step for
// the last read to return and a post step for the result; the next word
// is taken only after the post step.
// Reset: req_stall is held high for 16384 cycles while both stores are
// cleared one word per cycle, after which the filter is empty.
// A stalled response holds in the output register; the next request is
// still taken, and its own result waits until the register frees up.
`default_nettype none

module ipv4_bloom_filter
   import ibf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic             req_mode,
   input  wire logic [AddrW-1:0] req_address,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic             rsp_maybe_present
);

   state_type state_ff, state_in;

   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [WordAddrW-1:0] clr_ff, clr_in;
   logic [AddrW-1:0]     fwd_sh_ff, fwd_sh_in;
   logic [AddrW-1:0]     rev_sh_ff, rev_sh_in;
   logic                 mode_ff, mode_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_maybe_ff, rsp_maybe_in;

   logic [AddrW-1:0] rev_addr;
   logic             accept;
   logic             slot_free;
   logic             last_probe;
   logic             clear_done;
   logic             clear_en;
   logic             issue;
   logic             post_load;
   probe_type        fwd_probe, rev_probe;
   result_type       fwd_result, rev_result;

   // mirror the address
   always_comb begin
      for (int b = 0; b < AddrW; b++) begin
         rev_addr[b] = req_address[AddrW-1-b];
      end
   end

   assign accept     = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign last_probe = (cnt_ff == CntW'(HashCount - 1));
   assign clear_done = (clr_ff == {WordAddrW{1'b1}});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (last_probe) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_POST;
         end
         ST_POST: begin
            if (mode_ff == ModeInsert || slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      clear_en  = 1'b0;
      issue     = 1'b0;
      post_load = 1'b0;
      case (state_ff)
         ST_CLEAR:  clear_en  = 1'b1;
         ST_IDLE:   req_stall = 1'b0;
         ST_PROBE:  issue     = 1'b1;
         ST_FINISH: issue     = 1'b0;
         ST_POST:   post_load = (mode_ff == ModeQuery) && slot_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // window k is bits (31-k)..(13-k): shift the address up one bit per probe
   always_comb begin
      fwd_sh_in = fwd_sh_ff;
      rev_sh_in = rev_sh_ff;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         fwd_sh_in = req_address;
         rev_sh_in = rev_addr;
         mode_in   = req_mode;
         cnt_in    = '0;
      end else if (issue) begin
         fwd_sh_in = fwd_sh_ff << 1;
         rev_sh_in = rev_sh_ff << 1;
         cnt_in    = cnt_ff + CntW'(1);
      end
   end

   assign fwd_probe.valid = issue;
   assign fwd_probe.set   = (mode_ff == ModeInsert);
   assign fwd_probe.index = fwd_sh_ff[AddrW-1 -: IndexW];
   assign rev_probe.valid = issue;
   assign rev_probe.set   = (mode_ff == ModeInsert);
   assign rev_probe.index = rev_sh_ff[AddrW-1 -: IndexW];

   ibf_store u_fwd_store (
      .clock      (clock),
      .reset      (reset),
      .probe      (fwd_probe),
      .clear_en   (clear_en),
      .clear_addr (clr_ff),
      .result     (fwd_result)
   );

   ibf_store u_rev_store (
      .clock      (clock),
      .reset      (reset),
      .probe      (rev_probe),
      .clear_en   (clear_en),
      .clear_addr (clr_ff),
      .result     (rev_result)
   );

   // AND every probed bit of both stores
   always_comb begin
      hit_in = hit_ff;
      if (accept) begin
         hit_in = 1'b1;
      end else if (fwd_result.valid) begin
         hit_in = hit_ff & fwd_result.hit & rev_result.hit;
      end
   end

   assign clr_in = clear_en ? clr_ff + WordAddrW'(1) : clr_ff;

   // output register: load on post, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_maybe_in = rsp_maybe_ff;
      if (post_load) begin
         rsp_valid_in = 1'b1;
         rsp_maybe_in = hit_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_sh_ff    <= fwd_sh_in;
      rev_sh_ff    <= rev_sh_in;
      mode_ff      <= mode_in;
      hit_ff       <= hit_in;
      rsp_maybe_ff <= rsp_maybe_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_maybe_ff;

   // both stores return probe results in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      fwd_result.valid == rev_result.valid)
      else $error("store results out of step");

   // a response only appears right after a post cycle
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_POST))
      else $error("response without a finished query");

   // no probe overlaps the clearing pass
   a_no_probe_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !issue && !fwd_result.valid)
      else $error("probe during clear");

   // the final probe result arrives in the finish cycle
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> fwd_result.valid)
      else $error("last probe result missing");

   // a waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_maybe_ff))
      else $error("stalled response lost");

endmodule

`default_nettype wire
